// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] COLOR_RESET  = 8'd15;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTECT    = 1'b1;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_BSP   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_PUT,
        S_SCROLL,
        S_SCROLL_END,
        S_BLANK,
        S_CLEAR,
        S_READ,
        S_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic latch;          // take the incoming item
        logic addr_zero;
        logic addr_last_row;
        logic addr_inc;
        logic scroll_rd;      // read one row below, write it back in the following cycle
        logic blank_wr;       // blank the cell at the sweep address
        logic init;           // blanks use the reset colour
        logic newline;
        logic put_wr;
        logic bsp_wr;
        logic rd_load;
        logic rd_zero;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_action action;
        logic    is_newline;
        logic    col_full;
        logic    at_last_row;
        logic    bsp_ok;
        logic    idx_ok;
        logic    addr_at_end;
        logic    addr_at_scroll_end;
        logic    out_free;
    } t_status;

endpackage

// ===== rtl/text_console_writer_top.sv =====
// Channel   Dir  Handshake             Payload
// s (item)  in   i_s_tvalid/o_s_tready tdata: character[7:0], cell_index[18:8]; tuser: action
// m (item)  out  o_m_tvalid/i_m_tready tdata: cell_char, cell_color, cursor_row, cursor_col
// cfg       in   i_cfg_wr_en           i_cfg_index: 0 text_color, 1 protect_position
//
// A read past the end of the store skips the RAM read. Newline or wrap on the last row
// runs a row-shift over the single RAM write port; a wrapped character is written after
// the shift. Clear blanks one cell a cycle. After reset a clearing pass over all
// ROWS*COLUMNS cells runs with s_tready low; config writes are still taken. The result
// register holds while m_tready is low, and a finished item waits there until it frees
// before the next item is accepted.
module text_console_writer_top import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [23:0]           i_s_tdata,   // character[7:0], cell_index[18:8], zero
    input  logic [1:0]            i_s_tuser,   // action[1:0]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [31:0]           o_m_tdata,   // cell_char[7:0], cell_color[15:8],
                                               // cursor_row[20:16], cursor_col[27:21], zero
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd    cmd;
    t_status status;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_action     (i_s_tuser),
        .i_character  (i_s_tdata[7:0]),
        .i_cell_index (i_s_tdata[18:8]),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_m_tdata    (o_m_tdata)
    );

endmodule

// ===== rtl/tcw_ram.sv =====
module tcw_ram import tcw_pkg::*; #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tcw_ctrl.sv =====
module tcw_ctrl import tcw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_status.addr_at_end) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (i_status.action)
                    ACT_PUT: begin
                        if (i_status.is_newline || i_status.col_full) begin
                            if (i_status.at_last_row) begin
                                n_state = S_SCROLL;
                            end else if (i_status.is_newline) begin
                                n_state = S_RESP;
                            end else begin
                                n_state = S_PUT;
                            end
                        end else begin
                            n_state = S_PUT;
                        end
                    end
                    ACT_BSP:   n_state = S_RESP;
                    ACT_CLEAR: n_state = S_CLEAR;
                    ACT_READ:  n_state = i_status.idx_ok ? S_READ : S_RESP;
                    default:   n_state = S_RESP;
                endcase
            end
            S_PUT: n_state = S_RESP;
            S_SCROLL: begin
                if (i_status.addr_at_scroll_end) n_state = S_SCROLL_END;
            end
            S_SCROLL_END: n_state = S_BLANK;
            S_BLANK: begin
                if (i_status.addr_at_end) begin
                    n_state = i_status.is_newline ? S_RESP : S_PUT;
                end
            end
            S_CLEAR: begin
                if (i_status.addr_at_end) n_state = S_RESP;
            end
            S_READ: n_state = S_RESP;
            S_RESP: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.blank_wr = 1'b1;
                o_cmd.init     = 1'b1;
                o_cmd.addr_inc = 1'b1;
            end
            S_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.latch = i_s_tvalid;
            end
            S_DECODE: begin
                o_cmd.rd_zero   = 1'b1;
                o_cmd.addr_zero = 1'b1;
                unique case (i_status.action)
                    ACT_PUT: begin
                        o_cmd.newline = i_status.is_newline || i_status.col_full;
                    end
                    ACT_BSP: o_cmd.bsp_wr = i_status.bsp_ok;
                    default: ;
                endcase
            end
            S_PUT: o_cmd.put_wr = 1'b1;
            S_SCROLL: begin
                o_cmd.scroll_rd = 1'b1;
                o_cmd.addr_inc  = 1'b1;
            end
            // last copy lands here via the pending write
            S_SCROLL_END: o_cmd.addr_last_row = 1'b1;
            S_BLANK, S_CLEAR: begin
                o_cmd.blank_wr = 1'b1;
                o_cmd.addr_inc = 1'b1;
            end
            S_READ: o_cmd.rd_load = 1'b1;
            S_RESP: o_cmd.out_load = i_status.out_free;
            default: ;
        endcase
    end

endmodule

// ===== rtl/tcw_dp.sv =====
module tcw_dp import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [1:0]            i_action,
    input  logic [7:0]            i_character,
    input  logic [10:0]           i_cell_index,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [31:0]           o_m_tdata
);

    localparam int N  = ROWS * COLUMNS;
    localparam int AW = $clog2(N);
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS + 1);

    // item
    t_action      r_action;
    logic [7:0]   r_char;
    logic [10:0]  r_idx;
    // configuration
    logic [7:0]   r_color;
    logic [10:0]  r_protect;
    // console state
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [AW-1:0] r_last;
    // sweep
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_waddr;
    logic          r_wpend;
    // result
    logic [7:0]   r_res_char;
    logic [7:0]   r_res_color;
    logic         r_out_valid;
    logic [31:0]  r_out_data;

    logic [AW-1:0] pos;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;
    logic [7:0]    blank_color;

    assign pos         = AW'(AW'(r_row) * AW'(COLUMNS)) + AW'(r_col);
    assign blank_color = i_cmd.init ? COLOR_RESET : r_color;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = {blank_color, SPACE_CODE};
        priority if (r_wpend) begin
            ram_we    = 1'b1;
            ram_waddr = r_waddr;
            ram_wdata = ram_rdata;
        end else if (i_cmd.blank_wr) begin
            ram_we = 1'b1;
        end else if (i_cmd.put_wr) begin
            ram_we    = 1'b1;
            ram_waddr = pos;
            ram_wdata = {r_color, r_char};
        end else if (i_cmd.bsp_wr) begin
            ram_we    = 1'b1;
            ram_waddr = pos - AW'(1);
        end
    end

    assign ram_raddr = i_cmd.scroll_rd ? (r_addr + AW'(COLUMNS)) : AW'(r_idx);

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (N)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= t_action'(i_action);
            r_char   <= i_character;
            r_idx    <= i_cell_index;
        end
        r_waddr <= r_addr;
        if (i_cmd.rd_zero) begin
            r_res_char  <= '0;
            r_res_color <= '0;
        end else if (i_cmd.rd_load) begin
            r_res_char  <= ram_rdata[7:0];
            r_res_color <= ram_rdata[15:8];
        end
        if (i_cmd.out_load) begin
            r_out_data <= {4'd0, 7'(r_col), 5'(r_row), r_res_color, r_res_char};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color     <= COLOR_RESET;
            r_protect   <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_last      <= '0;
            r_addr      <= '0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_TEXT_COLOR: r_color   <= i_cfg_wdata[7:0];
                    CFG_PROTECT:    r_protect <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_wpend <= i_cmd.scroll_rd;
            priority if (i_cmd.addr_zero) begin
                r_addr <= '0;
            end else if (i_cmd.addr_last_row) begin
                r_addr <= AW'(N - COLUMNS);
            end else if (i_cmd.addr_inc) begin
                r_addr <= r_addr + AW'(1);
            end
            if (i_cmd.newline) begin
                r_col <= '0;
                if (!o_status.at_last_row) r_row <= r_row + RW'(1);
            end else if (i_cmd.put_wr) begin
                r_col  <= r_col + CW'(1);
                r_last <= pos;
            end else if (i_cmd.bsp_wr) begin
                r_col  <= r_col - CW'(1);
                r_last <= r_last - AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.action             = r_action;
        o_status.is_newline         = (r_char == NEWLINE_CODE);
        o_status.col_full           = (r_col >= CW'(COLUMNS));
        o_status.at_last_row        = (r_row == RW'(ROWS - 1));
        o_status.bsp_ok             = (32'(r_last) > 32'(r_protect)) && (r_col != '0);
        o_status.idx_ok             = (32'(r_idx) < 32'(N));
        o_status.addr_at_end        = (r_addr == AW'(N - 1));
        o_status.addr_at_scroll_end = (r_addr == AW'(N - COLUMNS - 1));
        o_status.out_free           = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
